### rtl/core/gce_pkg.sv
// ============================================================================
// gce_pkg - shared definitions for the glyph colour expander
// Geometry limits, register indexes, pixel modes and the colour widening.
// ============================================================================
`default_nettype none

package gce_pkg;

    // Geometry limits.
    localparam int COORD_BITS        = 12;
    localparam int MAX_BYTES_PER_ROW = 16;
    localparam int MAX_ROWS          = 64;

    // Field and register widths.
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 24;
    localparam int VALUE_W    = 24;
    localparam int COLOR_W    = 16;
    localparam int LEFT_W     = 12;
    localparam int TOP_W      = 12;
    localparam int STRIDE_W   = 13;
    localparam int BPR_W      = 5;
    localparam int ROWS_W     = 7;
    localparam int MODE_W     = 2;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 56;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(640);
    localparam logic [BPR_W-1:0]    BPR_RESET    = BPR_W'(1);
    localparam logic [ROWS_W-1:0]   ROWS_RESET   = ROWS_W'(8);
    localparam logic [COLOR_W-1:0]  FG_RESET     = 16'hffff;

    // Derived widths.
    localparam int COORD_USE = (COORD_BITS < LEFT_W) ? COORD_BITS : LEFT_W;
    localparam int RCW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int BCW  = (MAX_BYTES_PER_ROW > 1) ? $clog2(MAX_BYTES_PER_ROW) : 1;
    localparam int BPRW = $clog2(MAX_BYTES_PER_ROW + 1);
    localparam int RWS  = $clog2(MAX_ROWS + 1);
    localparam int YW   = ((COORD_USE > RCW) ? COORD_USE : RCW) + 1;
    localparam int XW   = ((COORD_USE > BCW + 3) ? COORD_USE : BCW + 3) + 1;
    localparam int SUMW = YW + STRIDE_W + 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DEST_LEFT     = 4'd0,
        REG_DEST_TOP      = 4'd1,
        REG_ROW_STRIDE    = 4'd2,
        REG_BYTES_PER_ROW = 4'd3,
        REG_GLYPH_ROWS    = 4'd4,
        REG_PIXEL_MODE    = 4'd5,
        REG_FG_COLOR      = 4'd6,
        REG_BG_COLOR      = 4'd7
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_16BIT = 2'd0,
        MODE_32BIT = 2'd1,
        MODE_NONE  = 2'd2,
        MODE_RSVD  = 2'd3
    } pixel_mode_t;

    // One byte's worth of pixels, handed to the emitter.
    typedef struct packed {
        logic [INDEX_W-1:0] base;
        logic [BYTE_W-1:0]  bits;
        logic               done;
    } burst_t;

    // Colour settings seen by the emitter.
    typedef struct packed {
        logic               wide;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
    } colour_t;

    function automatic logic [VALUE_W-1:0] widen_565(input logic [COLOR_W-1:0] c);
        return {c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
    endfunction

endpackage

`default_nettype wire

### rtl/core/gce_emitter.sv
// ============================================================================
// gce_emitter - pixel beat serialiser
// Holds one byte's burst and sends its eight pixels, MSB first, one beat per
// cycle unless the output stalls, through a registered output stage.
// ============================================================================
`default_nettype none

module gce_emitter (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load_valid,
    output logic                                    load_ready,
    input  wire gce_pkg::burst_t                    load_burst,
    input  wire gce_pkg::colour_t                   colours,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [23:0] pixel_index, [47:24] pixel_value, [48] glyph_done, rest zero
    output logic [gce_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    output logic                                    m_axis_tlast
);
    import gce_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    burst_t                burst_reg;
    logic [2:0]            bit_reg;
    logic [2:0]            bit_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [INDEX_W-1:0]    out_index_reg;
    logic [VALUE_W-1:0]    out_value_reg;
    logic                  out_last_reg;
    logic                  out_done_reg;

    logic                  issue;
    logic                  last_issue;
    logic                  load;
    logic                  pix_set;
    logic [COLOR_W-1:0]    colour_sel;
    logic [VALUE_W-1:0]    value_sel;

    assign issue      = busy_reg && (!out_valid_reg || m_axis_tready);
    assign last_issue = issue && (bit_reg == 3'd7);
    assign load_ready = !busy_reg || last_issue;
    assign load       = load_valid && load_ready;

    assign pix_set    = burst_reg.bits[3'd7 - bit_reg];
    assign colour_sel = pix_set ? colours.fg : colours.bg;
    assign value_sel  = colours.wide ? widen_565(colour_sel)
                                     : {{(VALUE_W-COLOR_W){1'b0}}, colour_sel};

    always_comb
    begin
        busy_next = busy_reg;
        bit_next  = bit_reg;
        if (load)
        begin
            busy_next = 1'b1;
            bit_next  = 3'd0;
        end
        else if (last_issue)
        begin
            busy_next = 1'b0;
        end
        else if (issue)
        begin
            bit_next = bit_reg + 3'd1;
        end
    end

    always_comb
    begin
        if (issue)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            bit_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            burst_reg <= load_burst;
        if (issue)
        begin
            out_index_reg <= burst_reg.base + INDEX_W'(bit_reg);
            out_value_reg <= value_sel;
            out_last_reg  <= (bit_reg == 3'd7);
            out_done_reg  <= burst_reg.done && (bit_reg == 3'd7);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-INDEX_W-VALUE_W-1){1'b0}},
                            out_done_reg, out_value_reg, out_index_reg};

endmodule

`default_nettype wire

### rtl/core/glyph_color_expander.sv
// ============================================================================
// glyph_color_expander - monochrome colour expansion of glyph bitmaps
// Each byte in 16/32-bit mode becomes eight foreground or background writes.
// ============================================================================
// Pipeline: a byte is registered in the input stage, then in the emitter's
// burst register, and each pixel, one output beat apiece, in the output
// register. The next byte can wait in the input stage while a burst is sent;
// with that stage empty, unsupported-mode bytes are absorbed at one per cycle.
// Reset: rst_n clears the glyph counters and pipeline valids and loads the
// register defaults; nothing needs clearing afterwards.
`default_nettype none

module glyph_color_expander (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [gce_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [gce_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [7:0] glyph_byte
    input  wire logic [gce_pkg::BYTE_W-1:0]         s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [23:0] pixel_index, [47:24] pixel_value, [48] glyph_done, rest zero
    output logic [gce_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    // last_of_byte
    output logic                                    m_axis_tlast
);
    import gce_pkg::*;

    logic [LEFT_W-1:0]   dest_left_reg;
    logic [TOP_W-1:0]    dest_top_reg;
    logic [STRIDE_W-1:0] row_stride_reg;
    logic [BPR_W-1:0]    bytes_per_row_reg;
    logic [ROWS_W-1:0]   glyph_rows_reg;
    pixel_mode_t         pixel_mode_reg;
    logic [COLOR_W-1:0]  fg_color_reg;
    logic [COLOR_W-1:0]  bg_color_reg;

    logic [RCW-1:0]      row_count_reg;
    logic [RCW-1:0]      row_count_next;
    logic [BCW-1:0]      byte_in_row_reg;
    logic [BCW-1:0]      byte_in_row_next;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [YW-1:0]       s1_y_reg;
    logic [XW-1:0]       s1_x_reg;
    logic [BYTE_W-1:0]   s1_byte_reg;
    logic                s1_done_reg;

    logic [BPRW-1:0]     bpr;
    logic [RWS-1:0]      rows;
    logic                end_row;
    logic                end_glyph;
    logic                accept;
    logic                cfg_hit;
    logic                supported;
    logic                load_ready;
    logic [SUMW-1:0]     base_sum;
    burst_t              burst;
    colour_t             colours;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign supported = (pixel_mode_reg == MODE_16BIT) || (pixel_mode_reg == MODE_32BIT);

    // Clamp the geometry to the supported ranges.
    always_comb
    begin
        if (bytes_per_row_reg == '0)
            bpr = BPRW'(1);
        else if (32'(bytes_per_row_reg) > MAX_BYTES_PER_ROW)
            bpr = BPRW'(MAX_BYTES_PER_ROW);
        else
            bpr = BPRW'(bytes_per_row_reg);

        if (glyph_rows_reg == '0)
            rows = RWS'(1);
        else if (32'(glyph_rows_reg) > MAX_ROWS)
            rows = RWS'(MAX_ROWS);
        else
            rows = RWS'(glyph_rows_reg);
    end

    assign end_row   = (32'(byte_in_row_reg) + 32'd1) >= 32'(bpr);
    assign end_glyph = end_row && ((32'(row_count_reg) + 32'd1) >= 32'(rows));

    // Configuration port.
    always_comb
    begin
        unique case (cfg_addr)
            REG_DEST_LEFT, REG_DEST_TOP, REG_ROW_STRIDE, REG_BYTES_PER_ROW,
            REG_GLYPH_ROWS, REG_PIXEL_MODE, REG_FG_COLOR, REG_BG_COLOR:
                cfg_hit = cfg_we;
            default:
                cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_left_reg     <= '0;
            dest_top_reg      <= '0;
            row_stride_reg    <= STRIDE_RESET;
            bytes_per_row_reg <= BPR_RESET;
            glyph_rows_reg    <= ROWS_RESET;
            pixel_mode_reg    <= MODE_16BIT;
            fg_color_reg      <= FG_RESET;
            bg_color_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_DEST_LEFT:     dest_left_reg     <= cfg_data[LEFT_W-1:0];
                REG_DEST_TOP:      dest_top_reg      <= cfg_data[TOP_W-1:0];
                REG_ROW_STRIDE:    row_stride_reg    <= cfg_data[STRIDE_W-1:0];
                REG_BYTES_PER_ROW: bytes_per_row_reg <= cfg_data[BPR_W-1:0];
                REG_GLYPH_ROWS:    glyph_rows_reg    <= cfg_data[ROWS_W-1:0];
                REG_PIXEL_MODE:    pixel_mode_reg    <= pixel_mode_t'(cfg_data[MODE_W-1:0]);
                REG_FG_COLOR:      fg_color_reg      <= cfg_data[COLOR_W-1:0];
                REG_BG_COLOR:      bg_color_reg      <= cfg_data[COLOR_W-1:0];
                default:           ;
            endcase
        end
    end

    // Position counters step per byte, written or not; a reg write clears them.
    always_comb
    begin
        row_count_next   = row_count_reg;
        byte_in_row_next = byte_in_row_reg;
        if (cfg_hit)
        begin
            row_count_next   = '0;
            byte_in_row_next = '0;
        end
        else if (accept)
        begin
            if (end_row)
            begin
                byte_in_row_next = '0;
                row_count_next   = end_glyph ? '0 : RCW'(row_count_reg + 1'b1);
            end
            else
            begin
                byte_in_row_next = BCW'(byte_in_row_reg + 1'b1);
            end
        end
    end

    // Input stage: row and column offsets of the byte.
    assign s_axis_tready = !s1_valid_reg || load_ready;

    always_comb
    begin
        if (accept)
            s1_valid_next = supported;
        else if (load_ready)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg   <= '0;
            byte_in_row_reg <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            row_count_reg   <= row_count_next;
            byte_in_row_reg <= byte_in_row_next;
            s1_valid_reg    <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_y_reg    <= YW'(dest_top_reg[COORD_USE-1:0]) + YW'(row_count_reg);
            s1_x_reg    <= XW'(dest_left_reg[COORD_USE-1:0])
                           + XW'({byte_in_row_reg, 3'b000});
            s1_byte_reg <= s_axis_tdata;
            s1_done_reg <= end_glyph;
        end
    end

    // The row multiply feeds the emitter's burst register directly.
    assign base_sum   = SUMW'(s1_y_reg) * SUMW'(row_stride_reg) + SUMW'(s1_x_reg);
    assign burst.base = INDEX_W'(base_sum);
    assign burst.bits = s1_byte_reg;
    assign burst.done = s1_done_reg;

    assign colours.wide = (pixel_mode_reg == MODE_32BIT);
    assign colours.fg   = fg_color_reg;
    assign colours.bg   = bg_color_reg;

    gce_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_valid    (s1_valid_reg),
        .load_ready    (load_ready),
        .load_burst    (burst),
        .colours       (colours),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### bench/gce_pixel_checker.sv
// ============================================================================
// gce_pixel_checker - scoreboard for the glyph colour expander
// Follows register writes and glyph bytes, predicts the eight pixel writes of
// each 16/32-bit mode byte and compares every output beat with the oldest one.
// ============================================================================

module gce_pixel_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gce_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [gce_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    // [7:0] glyph_byte
    input  logic [gce_pkg::BYTE_W-1:0]        in_byte,
    input  logic                              out_valid,
    input  logic                              out_ready,
    // [23:0] pixel_index, [47:24] pixel_value, [48] glyph_done, rest zero
    input  logic [gce_pkg::OUT_DATA_W-1:0]    out_data,
    input  logic                              out_last,
    output int                                failures,
    output int                                outstanding,
    output int                                bytes_seen,
    output int                                pixels_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import gce_pkg::*;

    localparam int REPORT_LIMIT = 40;
    localparam int DONE_BIT     = INDEX_W + VALUE_W;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic               last_of_byte;
        logic               glyph_done;
    } pixel_t;

    pixel_t pixel_queue [$];

    // Register copy and glyph position.
    logic [LEFT_W-1:0]   left_x;
    logic [TOP_W-1:0]    top_y;
    logic [STRIDE_W-1:0] stride;
    logic [BPR_W-1:0]    row_bytes;
    logic [ROWS_W-1:0]   row_total;
    pixel_mode_t         mode;
    logic [COLOR_W-1:0]  fg;
    logic [COLOR_W-1:0]  bg;
    logic [RCW-1:0]      cur_row;
    logic [BCW-1:0]      cur_byte;

    initial
    begin
        failures       = 0;
        outstanding    = 0;
        bytes_seen     = 0;
        pixels_checked = 0;
    end

    function automatic logic [VALUE_W-1:0] to_rgb888(input logic [COLOR_W-1:0] c);
        int unsigned cw;
        int unsigned rgb;
        cw  = c;
        rgb = (((cw >> 11) & 32'h1f) << 19) | (((cw >> 5) & 32'h3f) << 10)
            | ((cw & 32'h1f) << 3);
        return VALUE_W'(rgb);
    endfunction

    function automatic int unsigned clamp_count(input int unsigned v, input int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic apply_write(input logic [CFG_ADDR_W-1:0] addr,
                               input logic [CFG_DATA_W-1:0] data);
        logic hit;
        hit = 1'b1;
        case (addr)
            REG_DEST_LEFT:     left_x    = data[LEFT_W-1:0];
            REG_DEST_TOP:      top_y     = data[TOP_W-1:0];
            REG_ROW_STRIDE:    stride    = data[STRIDE_W-1:0];
            REG_BYTES_PER_ROW: row_bytes = data[BPR_W-1:0];
            REG_GLYPH_ROWS:    row_total = data[ROWS_W-1:0];
            REG_PIXEL_MODE:    mode      = pixel_mode_t'(data[MODE_W-1:0]);
            REG_FG_COLOR:      fg        = data[COLOR_W-1:0];
            REG_BG_COLOR:      bg        = data[COLOR_W-1:0];
            default:           hit       = 1'b0;
        endcase
        // Only a write that lands on a register restarts the glyph.
        if (hit)
        begin
            cur_row  = '0;
            cur_byte = '0;
        end
    endtask

    task automatic expand_byte(input logic [BYTE_W-1:0] b);
        int unsigned        bpr_eff;
        int unsigned        rows_eff;
        int unsigned        cmask;
        int unsigned        base;
        int                 i;
        logic               end_row;
        logic               end_glyph;
        logic [VALUE_W-1:0] fg_px;
        logic [VALUE_W-1:0] bg_px;
        pixel_t             px;
        bpr_eff   = clamp_count(row_bytes, MAX_BYTES_PER_ROW);
        rows_eff  = clamp_count(row_total, MAX_ROWS);
        cmask     = (1 << COORD_BITS) - 1;
        end_row   = (int'(cur_byte) + 1) >= bpr_eff;
        end_glyph = end_row && ((int'(cur_row) + 1) >= rows_eff);
        if (mode == MODE_16BIT || mode == MODE_32BIT)
        begin
            fg_px = (mode == MODE_32BIT) ? to_rgb888(fg) : VALUE_W'(fg);
            bg_px = (mode == MODE_32BIT) ? to_rgb888(bg) : VALUE_W'(bg);
            base  = ((top_y & cmask) + cur_row) * stride + (left_x & cmask) + cur_byte * 8;
            for (i = 0; i < 8; i++)
            begin
                px.index        = INDEX_W'(base + i);
                px.value        = b[7 - i] ? fg_px : bg_px;
                px.last_of_byte = (i == 7);
                px.glyph_done   = (i == 7) && end_glyph;
                pixel_queue.push_back(px);
            end
        end
        // The position advances in every mode, including the silent ones.
        if (end_row)
        begin
            cur_byte = '0;
            cur_row  = end_glyph ? '0 : cur_row + 1'b1;
        end
        else
        begin
            cur_byte = cur_byte + 1'b1;
        end
    endtask

    task automatic report(input string field, input longint unsigned want,
                          input longint unsigned got);
        failures++;
        if (failures <= REPORT_LIMIT)
            $error("%s: expected %0h, got %0h", field, want, got);
    endtask

    task automatic check_pixel();
        pixel_t want;
        pixels_checked++;
        if (pixel_queue.size() == 0)
        begin
            failures++;
            if (failures <= REPORT_LIMIT)
                $error("pixel beat with nothing expected: tdata %h tlast %b", out_data, out_last);
        end
        else
        begin
            want = pixel_queue.pop_front();
            if (out_data[INDEX_W-1:0] !== want.index)
                report("pixel_index", want.index, out_data[INDEX_W-1:0]);
            if (out_data[INDEX_W +: VALUE_W] !== want.value)
                report("pixel_value", want.value, out_data[INDEX_W +: VALUE_W]);
            if (out_last !== want.last_of_byte)
                report("last_of_byte", want.last_of_byte, out_last);
            if (out_data[DONE_BIT] !== want.glyph_done)
                report("glyph_done", want.glyph_done, out_data[DONE_BIT]);
            if (out_data[OUT_DATA_W-1:DONE_BIT+1] !== '0)
                report("tdata padding", 0, out_data[OUT_DATA_W-1:DONE_BIT+1]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_x    = '0;
            top_y     = '0;
            stride    = STRIDE_RESET;
            row_bytes = BPR_RESET;
            row_total = ROWS_RESET;
            mode      = MODE_16BIT;
            fg        = FG_RESET;
            bg        = '0;
            cur_row   = '0;
            cur_byte  = '0;
            pixel_queue.delete();
        end
        else
        begin
            if (cfg_we)
                apply_write(cfg_addr, cfg_data);
            if (in_valid && in_ready)
            begin
                bytes_seen++;
                expand_byte(in_byte);
            end
            if (out_valid && out_ready)
                check_pixel();
        end
        outstanding = pixel_queue.size();
    end

endmodule

### bench/tb_glyph_color_expander.sv
// ============================================================================
// tb_glyph_color_expander - testbench for the glyph colour expander
// Drives register settings and glyph bytes with random gaps and back-pressure;
// a separate scoreboard predicts and checks every pixel beat.
// ============================================================================

module tb_glyph_color_expander;
    timeunit 1ns;
    timeprecision 1ps;

    import gce_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RANDOM_ITEMS    = 96;
    localparam int MAX_WAIT        = 14;
    localparam int SETTLE_CYCLES   = 24;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TIMEOUT_NS      = 3_000_000;
    localparam int NUM_REGS        = 8;
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 4'd12;

    // Kinds of random phase.
    localparam int PHASE_SMALL    = 0;
    localparam int PHASE_WIDE_ROW = 1;
    localparam int PHASE_TALL     = 2;
    localparam int PHASE_PRESSURE = 3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    int          failures;
    int          outstanding;
    int          bytes_seen;
    int          pixels_checked;
    int          phases_run;
    int          result_bytes;
    bit          no_gaps;
    bit          hold_off_request;
    pixel_mode_t cur_mode;

    glyph_color_expander DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    gce_pixel_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_byte        (s_axis_tdata),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_data       (m_axis_tdata),
        .out_last       (m_axis_tlast),
        .failures       (failures),
        .outstanding    (outstanding),
        .bytes_seen     (bytes_seen),
        .pixels_checked (pixels_checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $error("timeout: pixel beats still outstanding: %0d", outstanding);
        $display("TEST FAILED");
        $finish;
    end

    // Adds random bits above the register width now and then; the block
    // must drop them.
    function automatic logic [CFG_DATA_W-1:0] with_noise(input int unsigned v, input int w);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom) << w;
        if ($urandom_range(0, 3) == 0)
            return CFG_DATA_W'(v) | noise;
        return CFG_DATA_W'(v);
    endfunction

    function automatic int unsigned clamp_count(input int unsigned v, input int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        if (addr == REG_PIXEL_MODE)
            cur_mode = pixel_mode_t'(data[MODE_W-1:0]);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Returns at the clock edge on which the byte is taken.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (cur_mode == MODE_16BIT || cur_mode == MODE_32BIT)
            result_bytes++;
    endtask

    // Stops the sender and lets the block empty before the next register write.
    // Bytes in the silent modes leave no trace, so a fixed settle follows.
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        phases_run++;
    endtask

    task automatic random_config(input int kind, output int unsigned glyph_len);
        int unsigned bpr;
        int unsigned rows;
        int unsigned pick;
        pixel_mode_t m;
        case (kind)
            PHASE_WIDE_ROW:
            begin
                bpr  = $urandom_range(MAX_BYTES_PER_ROW + 1, 31);
                rows = 1;
            end
            PHASE_TALL:
            begin
                bpr  = $urandom_range(0, 1);
                rows = $urandom_range(MAX_ROWS + 1, 127);
            end
            default:
            begin
                bpr  = $urandom_range(0, 4);
                rows = $urandom_range(0, 5);
            end
        endcase
        pick = $urandom_range(0, 9);
        if (kind != PHASE_SMALL)
            pick = pick % 8;
        m = (pick < 4) ? MODE_16BIT : (pick < 8) ? MODE_32BIT :
            (pick == 8) ? MODE_NONE : MODE_RSVD;
        write_reg(REG_DEST_LEFT, with_noise($urandom_range(0, 4095), LEFT_W));
        write_reg(REG_DEST_TOP, with_noise($urandom_range(0, 4095), TOP_W));
        write_reg(REG_ROW_STRIDE, with_noise(($urandom_range(0, 7) == 0) ?
                  $urandom_range(0, 8191) : $urandom_range(1, 4096), STRIDE_W));
        write_reg(REG_BYTES_PER_ROW, with_noise(bpr, BPR_W));
        write_reg(REG_GLYPH_ROWS, with_noise(rows, ROWS_W));
        write_reg(REG_PIXEL_MODE, with_noise(m, MODE_W));
        write_reg(REG_FG_COLOR, CFG_DATA_W'($urandom));
        write_reg(REG_BG_COLOR, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_ADDR_W'($urandom_range(NUM_REGS, 15)), CFG_DATA_W'($urandom));
        glyph_len = clamp_count(bpr, MAX_BYTES_PER_ROW) * clamp_count(rows, MAX_ROWS);
    endtask

    // Output side: a random stall before each beat, or one long hold-off on request.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold_off_request)
            begin
                stall            = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        int          phase;
        int          kind;
        int          count;
        int          shape;
        int unsigned glyph_len;
        logic [7:0]  b;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_addr         = '0;
        cfg_data         = '0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        no_gaps          = 1'b0;
        hold_off_request = 1'b0;
        phases_run       = 0;
        result_bytes     = 0;
        cur_mode         = MODE_16BIT;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset geometry: a full eight-row glyph, then the first byte of the next.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h3C);
        send_byte(8'hC3);
        send_byte(8'h7E);
        finish_phase();

        // A write outside the register map must not restart the glyph.
        write_reg(REG_UNMAPPED, 16'hFFFF);
        send_byte(8'h81);
        finish_phase();

        // Far corner with the largest stride, so the index wraps; 32-bit colour.
        write_reg(REG_DEST_LEFT, 16'h0FFF);
        write_reg(REG_DEST_TOP, 16'h0FFF);
        write_reg(REG_ROW_STRIDE, 16'h1FFF);
        write_reg(REG_BYTES_PER_ROW, 16'd2);
        write_reg(REG_GLYPH_ROWS, 16'd2);
        write_reg(REG_PIXEL_MODE, CFG_DATA_W'(MODE_32BIT));
        write_reg(REG_FG_COLOR, 16'hF81F);
        write_reg(REG_BG_COLOR, 16'h07E0);
        send_byte(8'hF0);
        send_byte(8'h0F);
        send_byte(8'hAA);
        send_byte(8'h55);
        finish_phase();

        // Zero stride, and zero counts that clamp to a one-byte glyph.
        write_reg(REG_ROW_STRIDE, 16'd0);
        write_reg(REG_BYTES_PER_ROW, 16'd0);
        write_reg(REG_GLYPH_ROWS, 16'd0);
        write_reg(REG_PIXEL_MODE, CFG_DATA_W'(MODE_16BIT));
        write_reg(REG_DEST_LEFT, 16'd0);
        write_reg(REG_DEST_TOP, 16'd0);
        write_reg(REG_FG_COLOR, 16'h0000);
        write_reg(REG_BG_COLOR, 16'hFFFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        finish_phase();

        // Largest in-range geometry; a colour write part-way restarts the glyph.
        write_reg(REG_ROW_STRIDE, 16'd4096);
        write_reg(REG_BYTES_PER_ROW, 16'd16);
        write_reg(REG_GLYPH_ROWS, 16'd64);
        write_reg(REG_DEST_LEFT, 16'd1);
        write_reg(REG_DEST_TOP, 16'd1);
        send_byte(8'h96);
        send_byte(8'h69);
        finish_phase();
        write_reg(REG_FG_COLOR, 16'h1234);
        send_byte(8'hE7);
        finish_phase();

        // Both unsupported mode codes take bytes and give no pixels.
        write_reg(REG_PIXEL_MODE, CFG_DATA_W'(MODE_NONE));
        send_byte(8'h18);
        send_byte(8'h24);
        finish_phase();
        write_reg(REG_PIXEL_MODE, CFG_DATA_W'(MODE_RSVD));
        send_byte(8'h42);
        send_byte(8'hBD);
        finish_phase();

        // Random settings, mostly whole glyphs; some cut short or run over.
        result_bytes = 0;
        phase        = 0;
        while (result_bytes < RANDOM_ITEMS)
        begin
            kind = (phase == 0) ? PHASE_PRESSURE : (phase == 1) ? PHASE_WIDE_ROW :
                   (phase == 2) ? PHASE_TALL : PHASE_SMALL;
            random_config(kind, glyph_len);
            case (kind)
                PHASE_SMALL:
                begin
                    count = glyph_len * $urandom_range(1, 2);
                    shape = $urandom_range(0, 3);
                    if (shape == 0)
                        count = $urandom_range(1, count);
                    else if (shape == 1)
                        count += $urandom_range(1, 3);
                end
                PHASE_PRESSURE:
                    count = 12;
                default:
                    count = glyph_len + 1;
            endcase
            no_gaps = (kind == PHASE_PRESSURE) || ($urandom_range(0, 3) == 0);
            // The output side stops after its next beat while bytes keep coming.
            if (kind == PHASE_PRESSURE)
                hold_off_request = 1'b1;
            repeat (count)
            begin
                b = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) :
                    8'($urandom_range(0, 255));
                send_byte(b);
            end
            finish_phase();
            no_gaps = 1'b0;
            phase++;
        end

        $display("Checked %0d pixel beats from %0d glyph bytes over %0d register phases,",
                 pixels_checked, bytes_seen, phases_run);
        $display("with both colour depths, silent modes, clamped geometry and index wrap.");
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
